FILE: design/pbs_pkg.sv
// Shared types, constants and helpers for the packet bandwidth shaper.
package pbs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int WINDOW_MS   = 20;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int QB_W   = LEN_W + CNT_W;
    localparam int USED_W = 20;
    localparam int RATE_W = 17;
    localparam int BUF_W  = 24;
    localparam int PROD_W = RATE_W + BUF_W;
    localparam int CFG_W  = 24;
    localparam int QCNT_W = 7;

    typedef enum logic [1:0] {
        OP_ARRIVE  = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_FLUSH   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        V_BYPASS   = 3'd0,
        V_QUEUED   = 3'd1,
        V_DROPPED  = 3'd2,
        V_RELEASED = 3'd3,
        V_NONE     = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_RATE    = 2'd0,
        CFG_BUFFER  = 2'd1,
        CFG_CAP_IN  = 2'd2,
        CFG_CAP_OUT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic             dir;
    } t_desc;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        t_desc            data;
    } t_ram_wr;

    // queue pointer advance with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

FILE: design/pbs_mul.sv
// Shared multiplier with registered product.
module pbs_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pbs_pkg::RATE_W-1:0]   i_a,
    input  logic [pbs_pkg::BUF_W-1:0]    i_b,
    output logic [pbs_pkg::PROD_W-1:0]   o_prod
);

    logic [pbs_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= pbs_pkg::PROD_W'(i_a) * pbs_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: design/pbs_desc_ram.sv
// Descriptor memory: one write port, one registered read port.
module pbs_desc_ram (
    input  logic                        i_clk,
    input  pbs_pkg::t_ram_wr            i_wr,
    input  logic [pbs_pkg::PTR_W-1:0]   i_rd_addr,
    output pbs_pkg::t_desc              o_rd_data
);

    pbs_pkg::t_desc r_mem [pbs_pkg::QUEUE_DEPTH];
    pbs_pkg::t_desc r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/packet_bandwidth_shaper.sv
// Top level of the packet bandwidth shaper: sequencer, queue state, result register.
// Usage:
//   Input channel (i_valid/o_ready) carries one command word: packet arrival,
//   release pass, window tick or flush. Output channel (o_valid/i_ready)
//   carries result words; o_last marks the final word of a command.
//   Config channel (i_cfg_valid/o_cfg_ready) writes rate, buffer depth and
//   the per-direction cap enables; write only while the block is idle.
// Timing:
//   A command is taken only in the idle state. The multiply state loads the
//   shared multiplier (buffer*rate for arrivals, WINDOW_MS*rate otherwise),
//   then the execute state emits one result word per cycle while the output
//   register can take it; the first word is registered in the execute state.
//   The descriptor memory read port (one read per cycle) sets the pop rate.
// Stall:
//   A held result word in the output register stalls the execute state;
//   nothing is lost. The next command may be accepted while the final word
//   of the previous one still waits.
// Reset: synchronous active-low; empties the queue, clears byte counters and
//   loads 300 kbps, 1000 ms, both directions capped. Memory is not cleared.
module packet_bandwidth_shaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_packet_tag,
    input  logic [15:0] i_packet_len,
    input  logic        i_is_outbound,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_out_tag,
    output logic [15:0] o_out_len,
    output logic        o_out_outbound,
    output logic [6:0]  o_queued_count,
    output logic        o_last,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // config registers
    logic [pbs_pkg::RATE_W-1:0] r_rate;
    logic [pbs_pkg::BUF_W-1:0]  r_buf_ms;
    logic                       r_cap_in;
    logic                       r_cap_out;

    // sequencer
    pbs_pkg::t_state r_state, n_state;

    // latched command word
    pbs_pkg::t_opcode           r_op;
    pbs_pkg::t_desc             r_pkt;

    // queue state
    logic [pbs_pkg::PTR_W-1:0]  r_rd, n_rd;
    logic [pbs_pkg::PTR_W-1:0]  r_wr, n_wr;
    logic [pbs_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pbs_pkg::QB_W-1:0]   r_qbytes, n_qbytes;
    logic [pbs_pkg::USED_W-1:0] r_used, n_used;

    // result register
    logic                       r_out_valid, n_out_valid;
    pbs_pkg::t_verdict          r_verdict, n_verdict;
    pbs_pkg::t_desc             r_out, n_out;
    logic [pbs_pkg::QCNT_W-1:0] r_qcnt, n_qcnt;
    logic                       r_last, n_last;

    logic                       w_in_acc;
    logic                       w_can_emit;
    logic                       w_finish;
    logic                       w_mul_en;
    logic [pbs_pkg::BUF_W-1:0]  w_mul_b;
    logic [pbs_pkg::PROD_W-1:0] w_prod;
    logic [pbs_pkg::PROD_W-4:0] w_limit;
    pbs_pkg::t_desc             w_head;
    pbs_pkg::t_ram_wr           w_wr;
    logic [pbs_pkg::QB_W:0]     w_qsum;
    logic [pbs_pkg::USED_W-1:0] w_used_pop;
    logic                       w_capped;
    logic                       w_more;
    logic [pbs_pkg::CNT_W-1:0]  w_cnt_dec;

    assign w_in_acc   = i_valid && o_ready;
    assign w_can_emit = !r_out_valid || i_ready;

    // ---- shared multiplier: buffer*rate for arrivals, window*rate otherwise
    assign w_mul_en = (r_state == pbs_pkg::S_MUL);
    assign w_mul_b  = (r_op == pbs_pkg::OP_ARRIVE) ? r_buf_ms
                                                   : pbs_pkg::BUF_W'(pbs_pkg::WINDOW_MS);

    pbs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (r_rate),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // byte limit: product / 8
    assign w_limit = w_prod[pbs_pkg::PROD_W-1:3];

    // ---- descriptor memory; read port always tracks the next head pointer
    pbs_desc_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (n_rd),
        .o_rd_data (w_head)
    );

    // ---- config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= pbs_pkg::RATE_W'(300);
            r_buf_ms  <= pbs_pkg::BUF_W'(1000);
            r_cap_in  <= 1'b1;
            r_cap_out <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pbs_pkg::t_cfg_idx'(i_cfg_index))
                pbs_pkg::CFG_RATE:    r_rate    <= i_cfg_data[pbs_pkg::RATE_W-1:0];
                pbs_pkg::CFG_BUFFER:  r_buf_ms  <= i_cfg_data[pbs_pkg::BUF_W-1:0];
                pbs_pkg::CFG_CAP_IN:  r_cap_in  <= i_cfg_data[0];
                pbs_pkg::CFG_CAP_OUT: r_cap_out <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbs_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = pbs_pkg::S_MUL;
                end
            end
            pbs_pkg::S_MUL: begin
                n_state = pbs_pkg::S_EXEC;
            end
            pbs_pkg::S_EXEC: begin
                if (w_finish) begin
                    n_state = pbs_pkg::S_IDLE;
                end
            end
            default: n_state = pbs_pkg::S_IDLE;
        endcase
    end

    // ---- execute datapath
    assign w_qsum     = {1'b0, r_qbytes} + (pbs_pkg::QB_W + 1)'(r_pkt.len);
    assign w_used_pop = r_used + pbs_pkg::USED_W'(w_head.len);
    assign w_capped   = r_pkt.dir ? r_cap_out : r_cap_in;
    assign w_cnt_dec  = r_count - pbs_pkg::CNT_W'(1);

    always_comb begin
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_count     = r_count;
        n_qbytes    = r_qbytes;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_ready;
        n_verdict   = r_verdict;
        n_out       = r_out;
        n_qcnt      = r_qcnt;
        n_last      = r_last;
        w_finish    = 1'b0;
        w_more      = 1'b0;
        w_wr.en     = 1'b0;
        w_wr.addr   = r_wr;
        w_wr.data   = r_pkt;

        if (r_state == pbs_pkg::S_EXEC && w_can_emit) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_last      = 1'b1;
            w_finish    = 1'b1;
            n_verdict   = pbs_pkg::V_NONE;
            case (r_op)
                pbs_pkg::OP_ARRIVE: begin
                    n_out = r_pkt;
                    if (!w_capped) begin
                        n_verdict = pbs_pkg::V_BYPASS;
                    end else if (r_count == pbs_pkg::CNT_W'(pbs_pkg::QUEUE_DEPTH) ||
                                 (pbs_pkg::PROD_W-3)'(w_qsum) > w_limit) begin
                        n_verdict = pbs_pkg::V_DROPPED;
                    end else begin
                        n_verdict = pbs_pkg::V_QUEUED;
                        w_wr.en   = 1'b1;
                        n_wr      = pbs_pkg::ptr_inc(r_wr);
                        n_count   = r_count + pbs_pkg::CNT_W'(1);
                        n_qbytes  = w_qsum[pbs_pkg::QB_W-1:0];
                    end
                end
                pbs_pkg::OP_RELEASE: begin
                    if (r_count != '0 && (pbs_pkg::PROD_W-3)'(r_used) < w_limit) begin
                        n_verdict = pbs_pkg::V_RELEASED;
                        n_out     = w_head;
                        n_rd      = pbs_pkg::ptr_inc(r_rd);
                        n_count   = w_cnt_dec;
                        n_qbytes  = r_qbytes - pbs_pkg::QB_W'(w_head.len);
                        n_used    = w_used_pop;
                        // look ahead: does the loop go on after this packet
                        w_more    = (w_cnt_dec != '0) &&
                                    ((pbs_pkg::PROD_W-3)'(w_used_pop) < w_limit);
                        n_last    = !w_more;
                        w_finish  = !w_more;
                    end
                end
                pbs_pkg::OP_TICK: begin
                    if ((pbs_pkg::PROD_W-3)'(r_used) <= w_limit) begin
                        n_used = '0;
                    end else begin
                        n_used = r_used - w_limit[pbs_pkg::USED_W-1:0];
                    end
                end
                pbs_pkg::OP_FLUSH: begin
                    if (r_count != '0) begin
                        n_verdict = pbs_pkg::V_RELEASED;
                        n_out     = w_head;
                        n_rd      = pbs_pkg::ptr_inc(r_rd);
                        n_count   = w_cnt_dec;
                        n_qbytes  = r_qbytes - pbs_pkg::QB_W'(w_head.len);
                        w_more    = (w_cnt_dec != '0);
                        n_last    = !w_more;
                        w_finish  = !w_more;
                    end
                end
                default: ;
            endcase
            n_qcnt = pbs_pkg::QCNT_W'(n_count);
        end
    end

    // ---- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbs_pkg::S_IDLE;
            r_rd        <= '0;
            r_wr        <= '0;
            r_count     <= '0;
            r_qbytes    <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_count     <= n_count;
            r_qbytes    <= n_qbytes;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= pbs_pkg::t_opcode'(i_opcode);
            r_pkt.tag <= i_packet_tag;
            r_pkt.len <= i_packet_len;
            r_pkt.dir <= i_is_outbound;
        end
        r_verdict <= n_verdict;
        r_out     <= n_out;
        r_qcnt    <= n_qcnt;
        r_last    <= n_last;
    end

    assign o_ready        = (r_state == pbs_pkg::S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_out_tag      = r_out.tag;
    assign o_out_len      = r_out.len;
    assign o_out_outbound = r_out.dir;
    assign o_queued_count = r_qcnt;
    assign o_last         = r_last;

    // ---- checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pbs_pkg::CNT_W'(pbs_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_qbytes == '0))
        else $error("empty queue holds bytes");

    a_mid_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_ready)
        else $error("command taken before burst ended");

    a_queued_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == pbs_pkg::V_QUEUED) |-> (o_queued_count != '0))
        else $error("queued verdict with empty queue");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == pbs_pkg::V_NONE) |->
            (o_out_tag == '0 && o_out_len == '0 && !o_out_outbound))
        else $error("empty result carries packet fields");

endmodule

FILE: verif/tb_packet_bandwidth_shaper.sv
// Self-checking testbench for the packet bandwidth shaper: directed and random commands.
module tb_packet_bandwidth_shaper;
    timeunit 1ns;
    timeprecision 1ps;

    // one result word as the shaper should present it
    typedef struct {
        pbs_pkg::t_verdict verdict;
        logic [15:0]       tag;
        logic [15:0]       len;
        logic              dir;
        logic [6:0]        qcnt;
        logic              last;
    } t_shaper_word;

    // traffic profiles for the random phases
    typedef enum int {
        MIX_TYPICAL,
        MIX_FILL,
        MIX_NOISE,
        MIX_EXTREME
    } t_mix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = pbs_pkg::OP_ARRIVE;
    logic [15:0] i_packet_tag = '0;
    logic [15:0] i_packet_len = '0;
    logic        i_is_outbound = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_verdict;
    logic [15:0] o_out_tag;
    logic [15:0] o_out_len;
    logic        o_out_outbound;
    logic [6:0]  o_queued_count;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = pbs_pkg::CFG_RATE;
    logic [23:0] i_cfg_data = '0;

    packet_bandwidth_shaper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_packet_tag   (i_packet_tag),
        .i_packet_len   (i_packet_len),
        .i_is_outbound  (i_is_outbound),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_out_tag      (o_out_tag),
        .o_out_len      (o_out_len),
        .o_out_outbound (o_out_outbound),
        .o_queued_count (o_queued_count),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shaper model state: config copy, descriptor queue, byte counters
    // ---------------------------------------------------------------
    logic [16:0]    cfg_rate = 17'd300;
    logic [23:0]    cfg_depth_ms = 24'd1000;
    logic           cfg_cap_in = 1'b1;
    logic           cfg_cap_out = 1'b1;
    pbs_pkg::t_desc held_q[$];
    logic [63:0]    held_bytes = '0;
    logic [63:0]    win_used = '0;

    // words the shaper still owes us, oldest first
    t_shaper_word expected_words[$];

    // bookkeeping
    int error_count = 0;
    int commands_sent = 0;
    int words_checked = 0;
    int reg_writes = 0;
    int drops_seen = 0;
    int releases_seen = 0;

    // idle control: percent chance of a burst, off entirely when quiet
    bit quiet = 1'b0;
    int gap_pct = 25;
    int stall_pct = 25;
    int hold_request = 0;
    int hold_left = 0;
    int stall_left = 0;

    function automatic void add_word(pbs_pkg::t_verdict v, logic [15:0] tag,
                                     logic [15:0] len, logic dir);
        t_shaper_word w;
        w.verdict = v;
        w.tag     = tag;
        w.len     = len;
        w.dir     = dir;
        w.qcnt    = 7'(held_q.size());
        w.last    = 1'b0;
        expected_words.push_back(w);
    endfunction

    // Work out every word one accepted command produces and update the model.
    function automatic void shape_command(pbs_pkg::t_opcode op, logic [15:0] tag,
                                          logic [15:0] len, logic dir);
        int             n_before;
        logic [63:0]    budget;
        logic [63:0]    buf_limit;
        logic           capped;
        pbs_pkg::t_desc d;
        n_before  = expected_words.size();
        budget    = (64'(pbs_pkg::WINDOW_MS) * 64'(cfg_rate)) / 64'd8;
        buf_limit = (64'(cfg_depth_ms) * 64'(cfg_rate)) / 64'd8;
        case (op)
            pbs_pkg::OP_ARRIVE: begin
                capped = dir ? cfg_cap_out : cfg_cap_in;
                if (!capped) begin
                    add_word(pbs_pkg::V_BYPASS, tag, len, dir);
                end else if (held_q.size() >= pbs_pkg::QUEUE_DEPTH ||
                             held_bytes + 64'(len) > buf_limit) begin
                    add_word(pbs_pkg::V_DROPPED, tag, len, dir);
                end else begin
                    d.tag = tag;
                    d.len = len;
                    d.dir = dir;
                    held_q.push_back(d);
                    held_bytes += 64'(len);
                    add_word(pbs_pkg::V_QUEUED, tag, len, dir);
                end
            end
            pbs_pkg::OP_RELEASE: begin
                // last packet out may push the window past its budget
                while (held_q.size() > 0 && win_used < budget) begin
                    d = held_q.pop_front();
                    win_used   += 64'(d.len);
                    held_bytes -= 64'(d.len);
                    add_word(pbs_pkg::V_RELEASED, d.tag, d.len, d.dir);
                end
            end
            pbs_pkg::OP_TICK: begin
                // overshoot carries into the next window
                if (win_used <= budget) begin
                    win_used = '0;
                end else begin
                    win_used -= budget;
                end
            end
            pbs_pkg::OP_FLUSH: begin
                // flushed bytes never count against the window
                while (held_q.size() > 0) begin
                    d = held_q.pop_front();
                    held_bytes -= 64'(d.len);
                    add_word(pbs_pkg::V_RELEASED, d.tag, d.len, d.dir);
                end
            end
            default: ;
        endcase
        if (expected_words.size() == n_before) begin
            add_word(pbs_pkg::V_NONE, '0, '0, 1'b0);
        end
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    // Offer one command word, wait for the handshake, then maybe go idle.
    task automatic send_command(pbs_pkg::t_opcode op, logic [15:0] tag, logic [15:0] len,
                                logic dir);
        int gap;
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_packet_tag  <= tag;
        i_packet_len  <= len;
        i_is_outbound <= dir;
        do @(posedge i_clk); while (!o_ready);
        shape_command(op, tag, len, dir);
        commands_sent++;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and sit until every owed word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // Write all four registers back to back on the config channel.
    task automatic write_all(logic [16:0] rate, logic [23:0] depth_ms, logic cap_in,
                             logic cap_out);
        logic [23:0] value [4];
        wait_drained();
        value[0] = 24'(rate);
        value[1] = depth_ms;
        value[2] = 24'(cap_in);
        value[3] = 24'(cap_out);
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= pbs_pkg::t_cfg_idx'(i);
            i_cfg_data  <= value[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (pbs_pkg::t_cfg_idx'(i))
                pbs_pkg::CFG_RATE:    cfg_rate     = value[i][16:0];
                pbs_pkg::CFG_BUFFER:  cfg_depth_ms = value[i];
                pbs_pkg::CFG_CAP_IN:  cfg_cap_in   = value[i][0];
                pbs_pkg::CFG_CAP_OUT: cfg_cap_out  = value[i][0];
                default: ;
            endcase
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side: compare every accepted word, drive i_ready
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_word();
        t_shaper_word w;
        if (expected_words.size() == 0) begin
            $error("result word with nothing pending: verdict %0d tag %0h",
                   o_verdict, o_out_tag);
            error_count++;
        end else begin
            w = expected_words.pop_front();
            check_field("verdict", 32'(w.verdict), 32'(o_verdict));
            check_field("out_tag", 32'(w.tag), 32'(o_out_tag));
            check_field("out_len", 32'(w.len), 32'(o_out_len));
            check_field("out_outbound", 32'(w.dir), 32'(o_out_outbound));
            check_field("queued_count", 32'(w.qcnt), 32'(o_queued_count));
            check_field("last", 32'(w.last), 32'(o_last));
            words_checked++;
            if (w.verdict == pbs_pkg::V_DROPPED) drops_seen++;
            if (w.verdict == pbs_pkg::V_RELEASED) releases_seen++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                check_word();
            end
            // long hold-off asked by the back-pressure test, counted here
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 8) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset config (300 kbps, 1000 ms): buffer limit 37500 bytes, window 750.
    task automatic test_directed();
        send_command(pbs_pkg::OP_ARRIVE, 16'h0000, 16'd0, 1'b0);       // zero length queued
        send_command(pbs_pkg::OP_ARRIVE, 16'hFFFF, 16'd1500, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'h1234, 16'd36000, 1'b0);   // fills buffer exactly
        send_command(pbs_pkg::OP_ARRIVE, 16'h2345, 16'd1, 1'b1);       // one byte over: drop
        send_command(pbs_pkg::OP_ARRIVE, 16'hFFFE, 16'hFFFF, 1'b0);    // max length: drop
        send_command(pbs_pkg::OP_RELEASE, 16'hFFFF, 16'hFFFF, 1'b1);   // overshoots window
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);   // budget spent: none
        send_command(pbs_pkg::OP_TICK, 16'h5555, 16'hAAAA, 1'b1);      // overshoot carried
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);   // still at budget
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);      // cleared
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);   // empty queue
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);     // empty flush
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        // inbound uncapped: bypass; outbound still queues
        write_all(17'd300, 24'd1000, 1'b0, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'hA0A0, 16'd800, 1'b0);
        send_command(pbs_pkg::OP_ARRIVE, 16'hB0B0, 16'd100, 1'b1);
        write_all(17'd300, 24'd1000, 1'b1, 1'b0);
        send_command(pbs_pkg::OP_ARRIVE, 16'hC0C0, 16'hFFFF, 1'b1);    // outbound bypass
        send_command(pbs_pkg::OP_ARRIVE, 16'hD0D0, 16'd200, 1'b0);
        send_command(pbs_pkg::OP_ARRIVE, 16'hE0E0, 16'd300, 1'b0);
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);     // three in order
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);   // window untouched
        write_all(17'd300, 24'd1000, 1'b1, 1'b1);
    endtask

    // Zero rate: no window budget, only zero-length capped packets fit.
    task automatic test_zero_rate();
        write_all(17'd0, 24'd1000, 1'b1, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'h0101, 16'd0, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'h0202, 16'd1, 1'b0);
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
    endtask

    // Largest rate and depth, then zero depth.
    task automatic test_config_extremes();
        write_all(17'd99999, 24'd9999999, 1'b1, 1'b1);
        for (int i = 0; i < 6; i++) begin
            send_command(pbs_pkg::OP_ARRIVE, 16'(16'hF000 + i), 16'hFFFF, 1'(i));
        end
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        write_all(17'd99999, 24'd0, 1'b1, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'h7777, 16'd1, 1'b1);
        send_command(pbs_pkg::OP_ARRIVE, 16'h8888, 16'd0, 1'b0);
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
    endtask

    // Fill the queue to its depth, overflow it, then empty it in one pass.
    task automatic test_queue_full();
        write_all(17'd300, 24'd1000, 1'b1, 1'b1);
        for (int i = 0; i < pbs_pkg::QUEUE_DEPTH + 2; i++) begin
            send_command(pbs_pkg::OP_ARRIVE, 16'($urandom()), 16'($urandom_range(0, 100)),
                         1'($urandom()));
        end
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
    endtask

    // Receiver goes deaf while commands keep coming; the input must stall.
    task automatic test_backpressure();
        int saved_gap;
        saved_gap = gap_pct;
        gap_pct = 0;
        write_all(17'd2000, 24'd50000, 1'b1, 1'b1);
        hold_request = 300;
        for (int i = 0; i < 24; i++) begin
            send_command(pbs_pkg::OP_ARRIVE, 16'($urandom()), 16'($urandom_range(0, 1500)),
                         1'($urandom()));
        end
        send_command(pbs_pkg::OP_RELEASE, 16'h0000, 16'h0000, 1'b0);
        send_command(pbs_pkg::OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
        // sender waits for every owed word before going on
        wait_drained();
        gap_pct = saved_gap;
    endtask

    // Random phases, each with its own config and traffic profile.
    task automatic test_random();
        t_mix             mix;
        pbs_pkg::t_opcode op;
        logic [15:0]      len;
        int               pick;
        int               rates [4];
        for (int p = 0; p < 7; p++) begin
            mix = t_mix'(p % 4);
            rates[0] = $urandom_range(0, 2) * 25;
            gap_pct   = rates[0];
            stall_pct = $urandom_range(0, 2) * 25;
            case (mix)
                MIX_TYPICAL: write_all(17'($urandom_range(50, 3000)),
                                       24'($urandom_range(50, 5000)),
                                       1'($urandom()), 1'($urandom()));
                MIX_FILL:    write_all(17'($urandom_range(100, 400)),
                                       24'($urandom_range(2000, 9999999)), 1'b1, 1'b1);
                MIX_NOISE:   write_all(17'($urandom_range(0, 99999)),
                                       24'($urandom_range(0, 9999999)),
                                       1'($urandom()), 1'($urandom()));
                default:     write_all($urandom_range(0, 1) ? 17'd99999 : 17'd0,
                                       $urandom_range(0, 1) ? 24'd9999999 : 24'd0,
                                       1'($urandom()), 1'($urandom()));
            endcase
            for (int i = 0; i < 30; i++) begin
                pick = $urandom_range(0, 99);
                if (mix == MIX_NOISE) begin
                    op = pbs_pkg::t_opcode'($urandom_range(0, 3));
                end else if (pick < ((mix == MIX_FILL) ? 85 : 60)) begin
                    op = pbs_pkg::OP_ARRIVE;
                end else if (pick < 88) begin
                    op = pbs_pkg::OP_RELEASE;
                end else if (pick < 97) begin
                    op = pbs_pkg::OP_TICK;
                end else begin
                    op = pbs_pkg::OP_FLUSH;
                end
                if (mix == MIX_FILL) begin
                    len = 16'($urandom_range(0, 200));
                end else if (mix == MIX_NOISE || $urandom_range(0, 3) == 0) begin
                    len = 16'($urandom());
                end else begin
                    len = 16'($urandom_range(0, 1500));
                end
                send_command(op, 16'($urandom()), len, 1'($urandom()));
            end
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        pbs_pkg::t_opcode op;
        write_all(17'd1000, 24'd400, 1'b1, 1'b1);
        quiet = 1'b1;
        for (int i = 0; i < 20; i++) begin
            op = ($urandom_range(0, 2) != 0) ? pbs_pkg::OP_ARRIVE
                                             : pbs_pkg::t_opcode'($urandom_range(1, 3));
            send_command(op, 16'($urandom()), 16'($urandom_range(0, 2000)), 1'($urandom()));
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        int drain_cycles;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_zero_rate();
        test_config_extremes();
        test_queue_full();
        test_backpressure();
        test_random();
        test_full_rate();

        // let the last words come back, then idle before checking
        i_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_words.size() != 0 && drain_cycles < 100000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (16) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            error_count++;
        end

        $display("Ran %0d commands and %0d register writes across rate, depth and cap settings.",
                 commands_sent, reg_writes);
        $display("Checked %0d result words: %0d released, %0d dropped.",
                 words_checked, releases_seen, drops_seen);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog: well past the slowest legal run
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
